// ----- rtl/core/dip_pkg.sv -----
package dip_pkg;

   // Field and register widths
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 8;
   localparam int VALUE_W     = 64;
   localparam int CODE_W      = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_SIZE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NEG_ENABLE  = 8'd1;

   localparam logic [COUNT_W-1:0] BUFFER_SIZE_RESET = 8'd21;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'd255;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Largest magnitude that can still take another digit
   localparam logic [VALUE_W-1:0] LIMIT_DIV10 = 64'd922337203685477580;
   localparam logic [VALUE_W-1:0] MIN_PATTERN = 64'h8000_0000_0000_0000;

   // Error codes
   localparam logic [CODE_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [CODE_W-1:0] ERR_TOO_LONG    = 3'd1;
   localparam logic [CODE_W-1:0] ERR_SIGN        = 3'd2;
   localparam logic [CODE_W-1:0] ERR_LEAD_ZERO   = 3'd3;
   localparam logic [CODE_W-1:0] ERR_NON_DIGIT   = 3'd4;
   localparam logic [CODE_W-1:0] ERR_OUT_OF_RANGE = 3'd5;

   // Per-identifier parse state; nacc tracks the negated magnitude
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               negative;
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] nacc;
      logic               sign_fault;
      logic               zero_lead;
      logic               bad_char;
      logic               range_fault;
      logic               at_minimum;
   } dip_state_type;

   typedef struct packed {
      logic               accepted;
      logic [VALUE_W-1:0] value;
      logic [CODE_W-1:0]  code;
   } dip_result_type;

   localparam dip_state_type STATE_CLEAR = '0;

endpackage

// ----- rtl/core/dip_req_if.sv -----
interface dip_req_if;
   import dip_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- rtl/core/dip_rsp_if.sv -----
interface dip_rsp_if;
   import dip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic signed [VALUE_W-1:0] id_value;
   logic [CODE_W-1:0]         error_code;

   modport source (output valid, output accepted, output id_value, output error_code,
                   input ready);
   modport sink   (input valid, input accepted, input id_value, input error_code,
                   output ready);
endinterface

// ----- rtl/core/dip_csr_if.sv -----
interface dip_csr_if;
   import dip_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/dip_char_step.sv -----
module dip_char_step (
   input  dip_pkg::dip_state_type        cur,
   input  logic [dip_pkg::CHAR_W-1:0]    char_code,
   input  logic [dip_pkg::COUNT_W-1:0]   buffer_size,
   input  logic                          neg_enable,
   output dip_pkg::dip_state_type        nxt,
   output dip_pkg::dip_result_type       result
);
   import dip_pkg::*;

   logic [CHAR_W-1:0]  digit_full;
   logic [3:0]         digit;
   logic               is_dash;
   logic               is_digit;
   logic               is_start;
   logic               over_limit;
   logic [VALUE_W-1:0] acc_times_ten;
   logic [VALUE_W-1:0] nacc_times_ten;

   assign digit_full = char_code - CHAR_ZERO;
   assign digit      = digit_full[3:0];
   assign is_dash    = (cur.count == '0) && (char_code == CHAR_MINUS);
   assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_start   = (cur.count == '0) || ((cur.count == 8'd1) && cur.negative);

   // x*10 as shift-and-add
   assign acc_times_ten  = {cur.acc[VALUE_W-4:0], 3'b000} + {cur.acc[VALUE_W-2:0], 1'b0};
   assign nacc_times_ten = {cur.nacc[VALUE_W-4:0], 3'b000} + {cur.nacc[VALUE_W-2:0], 1'b0};

   assign over_limit = (cur.acc > LIMIT_DIV10) || ((cur.acc == LIMIT_DIV10) && digit[3]);

   // Next state for one character
   always_comb begin
      nxt = cur;
      if (cur.count != COUNT_MAX) begin
         nxt.count = cur.count + 8'd1;
      end
      if (is_dash) begin
         nxt.negative = 1'b1;
         if (!neg_enable) begin
            nxt.sign_fault = 1'b1;
         end
      end else begin
         if (is_start && (char_code == CHAR_ZERO)) begin
            nxt.zero_lead = 1'b1;
         end
         if (!is_digit) begin
            nxt.bad_char = 1'b1;
         end else begin
            priority if (cur.range_fault) begin
               nxt.range_fault = 1'b1;
            end else if (cur.at_minimum) begin
               nxt.range_fault = 1'b1;
            end else if (over_limit) begin
               // only -9223372036854775808 survives the limit
               if (cur.negative && (cur.acc == LIMIT_DIV10) && (digit == 4'd8)) begin
                  nxt.at_minimum = 1'b1;
               end else begin
                  nxt.range_fault = 1'b1;
               end
            end else begin
               nxt.acc  = acc_times_ten + {{(VALUE_W-4){1'b0}}, digit};
               nxt.nacc = nacc_times_ten - {{(VALUE_W-4){1'b0}}, digit};
            end
         end
      end
   end

   // Verdict, valid only on the final character
   always_comb begin
      priority if (nxt.count >= buffer_size) begin
         result.code = ERR_TOO_LONG;
      end else if (nxt.sign_fault || (nxt.negative && (nxt.count < 8'd2))) begin
         result.code = ERR_SIGN;
      end else if (nxt.zero_lead) begin
         result.code = ERR_LEAD_ZERO;
      end else if (nxt.bad_char) begin
         result.code = ERR_NON_DIGIT;
      end else if (nxt.range_fault) begin
         result.code = ERR_OUT_OF_RANGE;
      end else begin
         result.code = ERR_NONE;
      end
      result.accepted = (result.code == ERR_NONE);
      priority if (!result.accepted) begin
         result.value = '0;
      end else if (nxt.at_minimum) begin
         result.value = MIN_PATTERN;
      end else if (nxt.negative) begin
         result.value = nxt.nacc;
      end else begin
         result.value = nxt.acc;
      end
   end

endmodule

// ----- rtl/core/decimal_id_parser.sv -----
// Decimal identifier parser: one text byte per word, verdict on the final byte.
// An accepted final byte passes the input register, then the result register, to rsp_ch.
// Throughput: one byte per cycle while rsp_ch does not stall, set by the single multiply-by-ten-add stage.
// Reset (synchronous, active high) empties both stages, clears the parse state
// and loads buffer_size 21 and neg_enable 0.
module decimal_id_parser (
   input logic clock,
   input logic reset,
   dip_req_if.sink   req_ch,
   dip_rsp_if.source rsp_ch,
   dip_csr_if.sink   csr_ch
);
   import dip_pkg::*;

   logic [COUNT_W-1:0] buffer_size_ff, buffer_size_in;
   logic               allow_neg_ff, allow_neg_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0]  s1_char_ff, s1_char_in;
   logic               s1_last_ff, s1_last_in;

   dip_state_type      state_ff, state_in;
   dip_state_type      state_step;
   dip_result_type     result_step;

   logic               rsp_valid_ff, rsp_valid_in;
   dip_result_type     rsp_ff, rsp_in;

   logic               stall;
   logic               advance;

   // Config writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      buffer_size_in = buffer_size_ff;
      allow_neg_in   = allow_neg_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_BUFFER_SIZE) begin
            buffer_size_in = csr_ch.wdata;
         end else if (csr_ch.index == REG_NEG_ENABLE) begin
            allow_neg_in = csr_ch.wdata[0];
         end
      end
   end

   // Pipeline flow control
   assign stall        = rsp_valid_ff && !rsp_ch.ready;
   assign advance      = s1_valid_ff && !stall;
   assign req_ch.ready = !s1_valid_ff || advance;

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff && !advance;
      s1_char_in  = s1_char_ff;
      s1_last_in  = s1_last_ff;
      if (req_ch.valid && req_ch.ready) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_ch.char_code;
         s1_last_in  = req_ch.is_last;
      end
   end

   dip_char_step u_step (
      .cur         (state_ff),
      .char_code   (s1_char_ff),
      .buffer_size (buffer_size_ff),
      .neg_enable  (allow_neg_ff),
      .nxt         (state_step),
      .result      (result_step)
   );

   // Parse state and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      if (advance) begin
         if (s1_last_ff) begin
            state_in     = STATE_CLEAR;
            rsp_valid_in = 1'b1;
            rsp_in       = result_step;
         end else begin
            state_in = state_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= BUFFER_SIZE_RESET;
         allow_neg_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         state_ff       <= STATE_CLEAR;
         rsp_valid_ff   <= 1'b0;
      end else begin
         buffer_size_ff <= buffer_size_in;
         allow_neg_ff   <= allow_neg_in;
         s1_valid_ff    <= s1_valid_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_char_ff <= s1_char_in;
      s1_last_ff <= s1_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accepted   = rsp_ff.accepted;
   assign rsp_ch.id_value   = $signed(rsp_ff.value);
   assign rsp_ch.error_code = rsp_ff.code;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dip_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int RAND_BYTES    = 100;
   localparam int RAND_IDS      = 10;
   localparam int REPORT_MAX    = 10;

   // First index past the two real registers; writes here must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 8'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dip_req_if req_ch ();
   dip_rsp_if rsp_ch ();
   dip_csr_if csr_ch ();

   decimal_id_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // Register copy held alongside the block
   logic [COUNT_W-1:0] cfg_buf   = BUFFER_SIZE_RESET;
   logic               cfg_allow = 1'b0;

   // Parse state of the identifier in flight
   logic [COUNT_W-1:0] id_count;
   logic               id_neg;
   logic [VALUE_W-1:0] id_acc;
   logic               id_at_min;
   logic               flt_sign;
   logic               flt_lead;
   logic               flt_char;
   logic               flt_range;

   dip_result_type verdict_q [$];
   int             faults    = 0;
   int             cycles    = 0;
   int             burst_left = 0;
   bit             no_idle   = 1'b0;
   int             stall_mode = 0;
   int             stall_left = 0;
   string          lim_digits = "922337203685477580";

   // Directed table
   typedef struct {
      string              text;
      int                 fill;
      logic [COUNT_W-1:0] buf_sz;
      logic               allow;
      bit                 typed;
      logic               accepted;
      logic [VALUE_W-1:0] value;
      logic [CODE_W-1:0]  code;
   } probe_row_type;

   localparam int N_PROBES = 25;

   probe_row_type probes [N_PROBES] = '{
      '{"7",                     0,   21, 1'b0, 1, 1'b1, 64'd7, ERR_NONE},
      '{"0",                     0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_LEAD_ZERO},
      '{"-5",                    0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_SIGN},
      '{"12a",                   0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_NON_DIGIT},
      '{"/:\377",                0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_NON_DIGIT},
      '{"9223372036854775807",   0,   21, 1'b0, 1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF,
        ERR_NONE},
      '{"9223372036854775808",   0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_OUT_OF_RANGE},
      '{"31415926535897932384",  0,   21, 1'b0, 0, 1'b0, 64'd0, ERR_NONE},
      '{"123456789012345678901", 0,   21, 1'b0, 1, 1'b0, 64'd0, ERR_TOO_LONG},
      '{"4096",                  0,   21, 1'b0, 0, 1'b0, 64'd0, ERR_NONE},
      '{"-",                     0,   21, 1'b1, 1, 1'b0, 64'd0, ERR_SIGN},
      '{"-0",                    0,   21, 1'b1, 1, 1'b0, 64'd0, ERR_LEAD_ZERO},
      '{"-9223372036854775808",  0,   21, 1'b1, 1, 1'b1, 64'h8000_0000_0000_0000,
        ERR_NONE},
      '{"-9223372036854775807",  0,   21, 1'b1, 1, 1'b1, 64'h8000_0000_0000_0001,
        ERR_NONE},
      '{"-9223372036854775809",  0,   21, 1'b1, 1, 1'b0, 64'd0, ERR_OUT_OF_RANGE},
      '{"-1-",                   0,   21, 1'b1, 1, 1'b0, 64'd0, ERR_NON_DIGIT},
      '{"--",                    0,   21, 1'b1, 1, 1'b0, 64'd0, ERR_NON_DIGIT},
      '{"-305",                  0,   21, 1'b1, 0, 1'b0, 64'd0, ERR_NONE},
      '{"-92233720368547758080", 0,  255, 1'b1, 1, 1'b0, 64'd0, ERR_OUT_OF_RANGE},
      '{"",                      300, 255, 1'b1, 1, 1'b0, 64'd0, ERR_TOO_LONG},
      '{"1",                     253, 255, 1'b1, 0, 1'b0, 64'd0, ERR_NONE},
      '{"5",                     0,    0, 1'b0, 1, 1'b0, 64'd0, ERR_TOO_LONG},
      '{"-12",                   0,    2, 1'b0, 1, 1'b0, 64'd0, ERR_TOO_LONG},
      '{"5",                     0,    2, 1'b0, 0, 1'b0, 64'd0, ERR_NONE},
      '{"8",                     0,    1, 1'b1, 1, 1'b0, 64'd0, ERR_TOO_LONG}
   };

   // Clear the per-identifier state
   function automatic void clear_parse();
      id_count  = '0;
      id_neg    = 1'b0;
      id_acc    = '0;
      id_at_min = 1'b0;
      flt_sign  = 1'b0;
      flt_lead  = 1'b0;
      flt_char  = 1'b0;
      flt_range = 1'b0;
   endfunction

   // Predictor: fold one byte in, return 1 with the verdict on the final byte
   function automatic bit parse_byte(input logic [CHAR_W-1:0] c, input logic last,
                                     output dip_result_type verdict);
      logic [COUNT_W-1:0] pos;
      logic [VALUE_W-1:0] d;
      logic [CODE_W-1:0]  code;
      verdict = '0;
      pos = id_count;
      if (id_count != COUNT_MAX) id_count = id_count + 8'd1;

      if (pos == 0 && c == CHAR_MINUS) begin
         id_neg = 1'b1;
         if (!cfg_allow) flt_sign = 1'b1;
      end else begin
         if ((pos == 0 || (pos == 1 && id_neg)) && c == CHAR_ZERO) flt_lead = 1'b1;
         if (c < CHAR_ZERO || c > CHAR_NINE) begin
            flt_char = 1'b1;
         end else if (!flt_range) begin
            d = {56'd0, c - CHAR_ZERO};
            // one digit past the smallest value is always out of range
            if (id_at_min) begin
               flt_range = 1'b1;
            end else if (id_acc > LIMIT_DIV10 || (id_acc == LIMIT_DIV10 && d > 7)) begin
               if (id_neg && id_acc == LIMIT_DIV10 && d == 8) id_at_min = 1'b1;
               else flt_range = 1'b1;
            end else begin
               id_acc = id_acc * 10 + d;
            end
         end
      end

      if (!last) return 1'b0;

      // priority: length, sign, leading zero, non-digit, range
      if (id_count >= cfg_buf)                     code = ERR_TOO_LONG;
      else if (flt_sign || (id_neg && id_count < 2)) code = ERR_SIGN;
      else if (flt_lead)                           code = ERR_LEAD_ZERO;
      else if (flt_char)                           code = ERR_NON_DIGIT;
      else if (flt_range)                          code = ERR_OUT_OF_RANGE;
      else                                         code = ERR_NONE;

      verdict.code     = code;
      verdict.accepted = (code == ERR_NONE);
      if (code == ERR_NONE) begin
         if (id_at_min)   verdict.value = MIN_PATTERN;
         else if (id_neg) verdict.value = 64'd0 - id_acc;
         else             verdict.value = id_acc;
      end
      clear_parse();
      return 1'b1;
   endfunction

   // Send one byte word; the sender works in bursts with gaps between them
   task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.is_last   <= last;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
   endtask

   // Send a whole identifier and queue what it should produce
   task automatic send_text(input logic [CHAR_W-1:0] text [$], input bit typed,
                            input dip_result_type fixed);
      dip_result_type verdict;
      logic           last;
      foreach (text[i]) begin
         last = (i == text.size() - 1);
         send_byte(text[i], last);
         if (parse_byte(text[i], last, verdict)) verdict_q.push_back(typed ? fixed : verdict);
      end
   endtask

   // Register write; hold keeps valid up for a following write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data, input bit hold);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (!hold) csr_ch.valid <= 1'b0;
      if (index == REG_BUFFER_SIZE)     cfg_buf   = data;
      else if (index == REG_NEG_ENABLE) cfg_allow = data[0];
   endtask

   // Wait for every pending verdict, then let the pipeline run dry
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random identifier: mostly well-formed, some broken, some noise
   task automatic make_text(output logic [CHAR_W-1:0] text [$]);
      int kind;
      int len;
      text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
         if ($urandom_range(0, 2) == 0) text.push_back(CHAR_MINUS);
         if (kind < 12) begin
            // around the int64 limits
            for (int i = 0; i < lim_digits.len(); i++) text.push_back(lim_digits[i]);
            text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 19) : $urandom_range(1, 9);
            text.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
            repeat (len - 1) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         // corrupt one byte now and then
         if (kind >= 50)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 80) begin
         repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
         if ($urandom_range(0, 1) == 0) text.push_back(CHAR_MINUS);
         text.push_back(CHAR_ZERO);
         repeat ($urandom_range(0, 4)) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 95) begin
         text.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
         repeat ($urandom_range(19, 39)) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else begin
         text.push_back(CHAR_MINUS);
         if ($urandom_range(0, 1) == 0) text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Receiver stalls: modes of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 80);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Result checker
   always @(posedge clock) begin
      dip_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdict_q.size() == 0) begin
            faults++;
            if (faults <= REPORT_MAX)
               $display("unexpected result word: accepted=%0b value=%0d code=%0d",
                        rsp_ch.accepted, rsp_ch.id_value, rsp_ch.error_code);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_ch.accepted !== want.accepted || rsp_ch.id_value !== want.value ||
                rsp_ch.error_code !== want.code) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display({"mismatch: expected accepted=%0b value=%0d code=%0d, ",
                            "got accepted=%0b value=%0d code=%0d"},
                           want.accepted, $signed(want.value), want.code,
                           rsp_ch.accepted, rsp_ch.id_value, rsp_ch.error_code);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [CHAR_W-1:0]  text [$];
      dip_result_type     fixed;
      logic [COUNT_W-1:0] bsz;
      int                 rand_bytes;
      int                 rand_ids;
      int                 ids_left;

      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.is_last   = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.wdata     = '0;
      rand_bytes       = 0;
      rand_ids         = 0;
      ids_left         = 0;
      clear_parse();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // an out-of-range index must leave both registers alone
      write_reg(REG_SPARE, 8'hFF, 0);

      // Directed table
      foreach (probes[r]) begin
         if (probes[r].buf_sz !== cfg_buf || probes[r].allow !== cfg_allow) begin
            settle();
            write_reg(REG_BUFFER_SIZE, probes[r].buf_sz, 1);
            write_reg(REG_NEG_ENABLE, {7'd0, probes[r].allow}, 0);
         end
         text.delete();
         repeat (probes[r].fill) text.push_back(CHAR_ZERO + 8'd1);
         for (int i = 0; i < probes[r].text.len(); i++) text.push_back(probes[r].text[i]);
         fixed = '{probes[r].accepted, probes[r].value, probes[r].code};
         send_text(text, probes[r].typed, fixed);
      end

      // Random phases, each with its own register setting
      fixed = '0;
      while (rand_bytes < RAND_BYTES || rand_ids < RAND_IDS) begin
         if (ids_left == 0) begin
            settle();
            if ($urandom_range(0, 3) == 0)
               write_reg(8'($urandom_range(REG_SPARE, 255)), 8'($urandom), 1);
            case ($urandom_range(0, 9))
               0:       bsz = 8'd0;
               1:       bsz = 8'd1;
               2:       bsz = COUNT_MAX;
               3:       bsz = 8'($urandom_range(0, 255));
               4:       bsz = 8'($urandom_range(2, 6));
               default: bsz = 8'($urandom_range(18, 40));
            endcase
            write_reg(REG_BUFFER_SIZE, bsz, 1);
            write_reg(REG_NEG_ENABLE, {7'($urandom), 1'($urandom_range(0, 3) != 0)}, 0);
            no_idle  = ($urandom_range(0, 3) == 0);
            ids_left = $urandom_range(6, 16);
         end
         make_text(text);
         rand_bytes += text.size();
         rand_ids++;
         ids_left--;
         send_text(text, 1'b0, fixed);
      end

      // Drain and finish
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (faults == 0 && verdict_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
